// ===== rtl/trtok_pkg.sv =====
`timescale 1ns / 1ps
package trtok_pkg;

  // Results one input byte can cause, at most
  localparam int unsigned MAX_RES = 6;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned QUEUE_DEPTH = 16;

  // Token kinds
  localparam logic [2:0] KIND_PRINT      = 3'd0;
  localparam logic [2:0] KIND_RAW        = 3'd1;
  localparam logic [2:0] KIND_EOL        = 3'd2;
  localparam logic [2:0] KIND_FONT_CODE  = 3'd3;
  localparam logic [2:0] KIND_FONT_COLOR = 3'd4;
  localparam logic [2:0] KIND_POSITION   = 3'd5;
  localparam logic [2:0] KIND_IMAGE      = 3'd6;
  localparam logic [2:0] KIND_END_PAGE   = 3'd7;

  // What the lookahead holds
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_HOLD = 2'd1;
  localparam logic [1:0] PEND_POS  = 2'd2;
  localparam logic [1:0] PEND_IMG  = 2'd3;

  // Control bytes
  localparam logic [7:0] BYTE_NUL       = 8'h00;
  localparam logic [7:0] BYTE_LF        = 8'h0A;
  localparam logic [7:0] BYTE_PRINT_LO  = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI  = 8'h7F;
  localparam logic [7:0] BYTE_END_PAGE  = 8'hF6;
  localparam logic [7:0] BYTE_IMAGE     = 8'hF7;
  localparam logic [7:0] BYTE_FONT_CODE = 8'hF9;
  localparam logic [7:0] BYTE_FONT_COL  = 8'hFA;
  localparam logic [7:0] BYTE_POSITION  = 8'hFB;
  localparam logic [7:0] BYTE_EOL_A     = 8'hFC;
  localparam logic [7:0] BYTE_EOL_B     = 8'hFD;
  localparam logic [7:0] BYTE_REC_END   = 8'hFE;
  localparam logic [7:0] BYTE_SUB_END   = 8'hFF;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] token_byte;
    logic [2:0] token_kind;
    logic       token_start;
    logic       token_finish;
    logic [7:0] text_char;
    logic       text_char_valid;
    logic       subrecord_end;
    logic       record_end;
    logic       missing_terminator;
    logic       run_last;
  } item_t;

  typedef item_t [MAX_RES-1:0] item_vec_t;

  typedef struct packed {
    logic [7:0] prev_byte;
    logic       have_prev;
    logic [7:0] pend_byte;
    logic       pend_cnt;
    logic [1:0] pend_kind;
    logic       in_img;
    logic       rec_closed;
    logic       sub_nonempty;
  } state_t;

endpackage

// ===== rtl/trtok_step.sv =====
`timescale 1ns / 1ps
module trtok_step (
  input  trtok_pkg::state_t                  state_i,
  input  logic [7:0]                         data_byte_i,
  input  logic                               final_byte_i,
  output trtok_pkg::state_t                  state_o,
  output trtok_pkg::item_vec_t               res_o,
  output logic [trtok_pkg::RES_CNT_W-1:0]    res_cnt_o
);
  import trtok_pkg::*;

  function automatic item_t mk_tok(logic [7:0] b, logic [2:0] kind, logic start,
                                   logic finish);
    item_t it;
    it = '0;
    it.byte_valid   = 1'b1;
    it.token_byte   = b;
    it.token_kind   = kind;
    it.token_start  = start;
    it.token_finish = finish;
    if (start) begin
      if (kind == KIND_PRINT) begin
        it.text_char = b;
        it.text_char_valid = 1'b1;
      end else if (kind == KIND_EOL || kind == KIND_END_PAGE || b == BYTE_NUL) begin
        it.text_char = BYTE_LF;
        it.text_char_valid = 1'b1;
      end
    end
    return it;
  endfunction

  function automatic item_t mk_single(logic [7:0] b);
    logic [2:0] k;
    if (b == BYTE_FONT_CODE) k = KIND_FONT_CODE;
    else if (b == BYTE_FONT_COL) k = KIND_FONT_COLOR;
    else if (b == BYTE_IMAGE) k = KIND_IMAGE;
    else if (b == BYTE_END_PAGE) k = KIND_END_PAGE;
    else if (b >= BYTE_PRINT_LO && b <= BYTE_PRINT_HI) k = KIND_PRINT;
    else k = KIND_RAW;
    return mk_tok(b, k, 1'b1, 1'b1);
  endfunction

  function automatic item_t mk_marker(logic sub, logic rec, logic miss);
    item_t it;
    it = '0;
    it.subrecord_end      = sub;
    it.record_end         = rec;
    it.missing_terminator = miss;
    return it;
  endfunction

  state_t                s;
  item_vec_t             res;
  logic [RES_CNT_W-1:0]  n;
  logic                  is_rec_end;
  logic                  is_sub_end;
  logic                  do_fresh;
  logic                  do_flush;
  logic [2:0]            font_kind;

  assign is_rec_end = (data_byte_i == BYTE_REC_END);
  assign is_sub_end = (data_byte_i == BYTE_SUB_END);

  always_comb begin
    s         = state_i;
    res       = '0;
    n         = '0;
    do_fresh  = 1'b0;
    do_flush  = 1'b0;
    font_kind = KIND_FONT_CODE;

    if (!state_i.rec_closed) begin
      // Tokenize a data byte
      if (!is_rec_end && !is_sub_end) begin
        s.sub_nonempty = 1'b1;
        case (s.pend_kind)
          PEND_HOLD: begin
            s.pend_kind = PEND_NONE;
            if (s.pend_byte == BYTE_FONT_CODE || s.pend_byte == BYTE_FONT_COL) begin
              font_kind = (s.pend_byte == BYTE_FONT_CODE) ? KIND_FONT_CODE
                                                          : KIND_FONT_COLOR;
              res[n] = mk_tok(s.pend_byte, font_kind, 1'b1, 1'b0); n = n + 1'b1;
              res[n] = mk_tok(data_byte_i, font_kind, 1'b0, 1'b1); n = n + 1'b1;
              s.prev_byte = data_byte_i;
            end else if (data_byte_i == BYTE_NUL) begin
              res[n] = mk_tok(s.pend_byte, KIND_EOL, 1'b1, 1'b0); n = n + 1'b1;
              res[n] = mk_tok(data_byte_i, KIND_EOL, 1'b0, 1'b1); n = n + 1'b1;
              s.prev_byte = data_byte_i;
            end else begin
              res[n] = mk_tok(s.pend_byte, KIND_RAW, 1'b1, 1'b1); n = n + 1'b1;
              do_fresh = 1'b1;
            end
          end
          PEND_POS: begin
            if (!s.pend_cnt) begin
              s.pend_byte = data_byte_i;
              s.pend_cnt  = 1'b1;
            end else begin
              res[n] = mk_tok(s.prev_byte, KIND_POSITION, 1'b1, 1'b0); n = n + 1'b1;
              res[n] = mk_tok(BYTE_POSITION, KIND_POSITION, 1'b0, 1'b0); n = n + 1'b1;
              res[n] = mk_tok(s.pend_byte, KIND_POSITION, 1'b0, 1'b0); n = n + 1'b1;
              res[n] = mk_tok(data_byte_i, KIND_POSITION, 1'b0, 1'b1); n = n + 1'b1;
              s.pend_kind = PEND_NONE;
              s.pend_cnt  = 1'b0;
              s.prev_byte = data_byte_i;
            end
          end
          PEND_IMG: begin
            res[n] = mk_tok(s.pend_byte, KIND_IMAGE, !s.in_img, 1'b0); n = n + 1'b1;
            s.in_img = 1'b1;
            if (data_byte_i == BYTE_NUL) begin
              res[n] = mk_tok(data_byte_i, KIND_IMAGE, 1'b0, 1'b1); n = n + 1'b1;
              s.pend_kind = PEND_NONE;
              s.in_img    = 1'b0;
            end else begin
              s.pend_byte = data_byte_i;
            end
            s.prev_byte = data_byte_i;
          end
          default: do_fresh = 1'b1;
        endcase

        // Start a new token on this byte
        if (do_fresh) begin
          if (data_byte_i == BYTE_EOL_A || data_byte_i == BYTE_EOL_B ||
              data_byte_i == BYTE_FONT_CODE || data_byte_i == BYTE_FONT_COL) begin
            s.pend_kind = PEND_HOLD;
            s.pend_byte = data_byte_i;
            s.prev_byte = data_byte_i;
            s.have_prev = 1'b1;
          end else if (data_byte_i == BYTE_POSITION && s.have_prev) begin
            // keep prev_byte: it opens the position token
            s.pend_kind = PEND_POS;
            s.pend_cnt  = 1'b0;
          end else if (data_byte_i == BYTE_IMAGE) begin
            s.pend_kind = PEND_IMG;
            s.pend_byte = data_byte_i;
            s.in_img    = 1'b0;
            s.prev_byte = data_byte_i;
            s.have_prev = 1'b1;
          end else begin
            res[n] = mk_single(data_byte_i); n = n + 1'b1;
            s.prev_byte = data_byte_i;
            s.have_prev = 1'b1;
          end
        end
      end

      // Resolve what the lookahead still holds
      do_flush = is_rec_end || is_sub_end || final_byte_i;
      if (do_flush) begin
        case (s.pend_kind)
          PEND_HOLD: begin
            res[n] = mk_single(s.pend_byte); n = n + 1'b1;
          end
          PEND_POS: begin
            res[n] = mk_tok(BYTE_POSITION, KIND_RAW, 1'b1, 1'b1); n = n + 1'b1;
            if (s.pend_cnt) begin
              res[n] = mk_single(s.pend_byte); n = n + 1'b1;
            end
          end
          PEND_IMG: begin
            res[n] = mk_tok(s.pend_byte, KIND_IMAGE, !s.in_img, 1'b1); n = n + 1'b1;
          end
          default: ;
        endcase
        s.pend_kind = PEND_NONE;
        s.pend_cnt  = 1'b0;
        s.in_img    = 1'b0;
      end

      // Markers
      if (is_rec_end) begin
        res[n] = mk_marker(1'b1, 1'b1, 1'b0); n = n + 1'b1;
      end else if (is_sub_end) begin
        res[n] = mk_marker(1'b1, 1'b0, 1'b0); n = n + 1'b1;
        if (final_byte_i) begin
          res[n] = mk_marker(1'b0, 1'b1, 1'b1); n = n + 1'b1;
        end
      end else if (final_byte_i) begin
        res[n] = mk_marker(s.sub_nonempty, 1'b1, 1'b1); n = n + 1'b1;
      end

      // Close the subrecord on a separator
      if (is_rec_end || is_sub_end) begin
        s.prev_byte    = '0;
        s.have_prev    = 1'b0;
        s.pend_cnt     = 1'b0;
        s.pend_kind    = PEND_NONE;
        s.in_img       = 1'b0;
        s.sub_nonempty = 1'b0;
        s.rec_closed   = is_rec_end;
      end

      if (n != '0) begin
        res[n - 1'b1].run_last = 1'b1;
      end
    end

    // The record's last byte returns to the reset state
    if (final_byte_i) begin
      s = '0;
    end
  end

  assign state_o   = s;
  assign res_o     = res;
  assign res_cnt_o = n;

endmodule

// ===== rtl/text_record_control_code_tokenizer.sv =====
`timescale 1ns / 1ps
// Tokenizer for the bytes of one text record.
// Input channel: in_valid_i / in_ready_o carry one record byte per item, with
// final_byte_i set on the record's last byte. Output channel: out_valid_o /
// out_ready_i carry one result item per transfer: a token byte with its kind,
// start/finish flags and decoded character, or a marker (byte_valid_o low)
// for a subrecord end, a record end or a missing terminator. run_last_o
// flags the last result caused by one input byte (up to six per byte).
// Data path: an input byte is taken into the input register, and its
// results are written into the output queue once the queue has room; the
// queue head drives the result ports.
// Throughput: one input byte per cycle while the queue has room and one
// result per cycle while the receiver is ready. The input register drains
// into the queue only while the queue has room for six results, so the
// queue depth (QueueDepth) sets how long a burst of multi-result bytes is
// absorbed while the receiver stalls; a stalled receiver backs up the queue
// and then the input.
// Reset clears the tokenizer state, the input register and the queue.
module text_record_control_code_tokenizer #(
  parameter int unsigned QueueDepth = trtok_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] token_byte_o,
  output logic [2:0] token_kind_o,
  output logic       token_start_o,
  output logic       token_finish_o,
  output logic [7:0] text_char_o,
  output logic       text_char_valid_o,
  output logic       subrecord_end_o,
  output logic       record_end_o,
  output logic       missing_terminator_o,
  output logic       run_last_o
);
  import trtok_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = PtrW + 1;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 in_final_q;
  state_t               state_q;
  state_t               state_d;
  item_vec_t            step_res;
  logic [RES_CNT_W-1:0] step_n;
  logic                 consume;
  logic                 pop;
  item_t                queue_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q;
  logic [PtrW-1:0]      rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      cnt_d;
  item_t                head;

  trtok_step u_step (
    .state_i      (state_q),
    .data_byte_i  (in_byte_q),
    .final_byte_i (in_final_q),
    .state_o      (state_d),
    .res_o        (step_res),
    .res_cnt_o    (step_n)
  );

  // Drain the input register only when the queue can take a full burst
  assign consume    = in_valid_q && (cnt_q <= CntW'(QueueDepth - MAX_RES));
  assign in_ready_o = !in_valid_q || consume;
  assign pop        = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (consume) begin
      cnt_d = cnt_d + CntW'(step_n);
    end
    if (pop) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (consume) begin
        state_q  <= state_d;
        wr_ptr_q <= wr_ptr_q + PtrW'(step_n);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q  <= data_byte_i;
      in_final_q <= final_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (RES_CNT_W'(i) < step_n) begin
          queue_q[wr_ptr_q + PtrW'(i)] <= step_res[i];
        end
      end
    end
  end

  assign head                 = queue_q[rd_ptr_q];
  assign out_valid_o          = (cnt_q != '0);
  assign byte_valid_o         = head.byte_valid;
  assign token_byte_o         = head.token_byte;
  assign token_kind_o         = head.token_kind;
  assign token_start_o        = head.token_start;
  assign token_finish_o       = head.token_finish;
  assign text_char_o          = head.text_char;
  assign text_char_valid_o    = head.text_char_valid;
  assign subrecord_end_o      = head.subrecord_end;
  assign record_end_o         = head.record_end;
  assign missing_terminator_o = head.missing_terminator;
  assign run_last_o           = head.run_last;

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("output queue count beyond its depth");

  a_closed_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && state_q.rec_closed |-> step_n == '0)
    else $error("bytes after the record end produced results");

  a_input_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |=> in_valid_q && $stable(in_byte_q) && $stable(in_final_q))
    else $error("input register lost a waiting item");

  a_final_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_final_q |=> state_q == '0)
    else $error("state not cleared after the record's last byte");

endmodule

// ===== sim/token_stream_checker.sv =====
`timescale 1ns / 1ps
module token_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic       byte_valid_i,
  input  logic [7:0] token_byte_i,
  input  logic [2:0] token_kind_i,
  input  logic       token_start_i,
  input  logic       token_finish_i,
  input  logic [7:0] text_char_i,
  input  logic       text_char_valid_i,
  input  logic       subrecord_end_i,
  input  logic       record_end_i,
  input  logic       missing_terminator_i,
  input  logic       run_last_i,
  output int         mismatch_count_o,
  output int         outstanding_o
);
  import trtok_pkg::*;

  // Tokenizer state as the block should hold it
  logic [7:0] prev_q;
  logic       have_prev_q;
  logic [7:0] held_q [2];
  logic [1:0] held_cnt_q;
  logic [1:0] held_kind_q;
  logic       in_img_q;
  logic       rec_closed_q;
  logic       sub_nonempty_q;

  item_t step_results[$];
  item_t expected_tokens[$];
  int    mismatches;

  assign mismatch_count_o = mismatches;

  task automatic push_result(input logic bv, input logic [7:0] b, input logic [2:0] kind,
                             input logic start, input logic finish, input logic [7:0] ch,
                             input logic chv, input logic sub, input logic rec,
                             input logic miss);
    item_t r;
    r = '0;
    r.byte_valid         = bv;
    r.token_byte         = b;
    r.token_kind         = kind;
    r.token_start        = start;
    r.token_finish       = finish;
    r.text_char          = ch;
    r.text_char_valid    = chv;
    r.subrecord_end      = sub;
    r.record_end         = rec;
    r.missing_terminator = miss;
    if (step_results.size() < MAX_RES) step_results = {step_results, r};
  endtask

  task automatic push_marker(input logic sub, input logic rec, input logic miss);
    push_result(1'b0, 8'h00, KIND_PRINT, 1'b0, 1'b0, 8'h00, 1'b0, sub, rec, miss);
  endtask

  // Decoded character only on a token start that follows the text rules
  task automatic emit_token(input logic [7:0] b, input logic [2:0] kind, input logic start,
                            input logic finish, input logic text_rule);
    logic [7:0] ch;
    logic       chv;
    ch  = 8'h00;
    chv = 1'b0;
    if (start && text_rule) begin
      if (kind == KIND_PRINT) begin
        ch  = b;
        chv = 1'b1;
      end else if (kind == KIND_EOL || kind == KIND_END_PAGE || b == BYTE_NUL) begin
        ch  = BYTE_LF;
        chv = 1'b1;
      end
    end
    push_result(1'b1, b, kind, start, finish, ch, chv, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic emit_single(input logic [7:0] b);
    logic [2:0] kind;
    if (b == BYTE_FONT_CODE) kind = KIND_FONT_CODE;
    else if (b == BYTE_FONT_COL) kind = KIND_FONT_COLOR;
    else if (b == BYTE_IMAGE) kind = KIND_IMAGE;
    else if (b == BYTE_END_PAGE) kind = KIND_END_PAGE;
    else if (b >= BYTE_PRINT_LO && b <= BYTE_PRINT_HI) kind = KIND_PRINT;
    else kind = KIND_RAW;
    emit_token(b, kind, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic clear_subrecord();
    prev_q         = 8'h00;
    have_prev_q    = 1'b0;
    held_cnt_q     = 2'd0;
    held_kind_q    = PEND_NONE;
    in_img_q       = 1'b0;
    sub_nonempty_q = 1'b0;
  endtask

  task automatic reset_state();
    clear_subrecord();
    held_q[0]    = 8'h00;
    held_q[1]    = 8'h00;
    rec_closed_q = 1'b0;
  endtask

  task automatic take_fresh(input logic [7:0] b);
    if (b == BYTE_EOL_A || b == BYTE_EOL_B || b == BYTE_FONT_CODE || b == BYTE_FONT_COL) begin
      held_kind_q = PEND_HOLD;
      held_q[0]   = b;
    end else if (b == BYTE_POSITION && have_prev_q) begin
      // keep prev_q: it opens the position token
      held_kind_q = PEND_POS;
      held_cnt_q  = 2'd0;
      return;
    end else if (b == BYTE_IMAGE) begin
      held_kind_q = PEND_IMG;
      held_q[0]   = b;
      in_img_q    = 1'b0;
    end else begin
      emit_single(b);
    end
    prev_q      = b;
    have_prev_q = 1'b1;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0] h;
    logic [2:0] fk;
    sub_nonempty_q = 1'b1;
    case (held_kind_q)
      PEND_HOLD: begin
        h           = held_q[0];
        held_kind_q = PEND_NONE;
        if (h == BYTE_FONT_CODE || h == BYTE_FONT_COL) begin
          fk = (h == BYTE_FONT_CODE) ? KIND_FONT_CODE : KIND_FONT_COLOR;
          emit_token(h, fk, 1'b1, 1'b0, 1'b1);
          emit_token(b, fk, 1'b0, 1'b1, 1'b0);
          prev_q = b;
        end else if (b == BYTE_NUL) begin
          emit_token(h, KIND_EOL, 1'b1, 1'b0, 1'b1);
          emit_token(b, KIND_EOL, 1'b0, 1'b1, 1'b0);
          prev_q = b;
        end else begin
          emit_token(h, KIND_RAW, 1'b1, 1'b1, 1'b1);
          take_fresh(b);
        end
      end
      PEND_POS: begin
        if (held_cnt_q == 2'd0) begin
          held_q[0]  = b;
          held_cnt_q = 2'd1;
        end else begin
          emit_token(prev_q, KIND_POSITION, 1'b1, 1'b0, 1'b1);
          emit_token(BYTE_POSITION, KIND_POSITION, 1'b0, 1'b0, 1'b0);
          emit_token(held_q[0], KIND_POSITION, 1'b0, 1'b0, 1'b0);
          emit_token(b, KIND_POSITION, 1'b0, 1'b1, 1'b0);
          held_kind_q = PEND_NONE;
          held_cnt_q  = 2'd0;
          prev_q      = b;
        end
      end
      PEND_IMG: begin
        emit_token(held_q[0], KIND_IMAGE, !in_img_q, 1'b0, 1'b1);
        in_img_q = 1'b1;
        if (b == BYTE_NUL) begin
          emit_token(b, KIND_IMAGE, 1'b0, 1'b1, 1'b0);
          held_kind_q = PEND_NONE;
          in_img_q    = 1'b0;
        end else begin
          held_q[0] = b;
        end
        prev_q = b;
      end
      default: take_fresh(b);
    endcase
  endtask

  // Resolve lookahead as at the end of the data
  task automatic resolve_held();
    case (held_kind_q)
      PEND_HOLD: emit_single(held_q[0]);
      PEND_POS: begin
        emit_token(BYTE_POSITION, KIND_RAW, 1'b1, 1'b1, 1'b1);
        if (held_cnt_q != 2'd0) emit_single(held_q[0]);
      end
      PEND_IMG: emit_token(held_q[0], KIND_IMAGE, !in_img_q, 1'b1, 1'b1);
      default: ;
    endcase
    held_kind_q = PEND_NONE;
    held_cnt_q  = 2'd0;
    in_img_q    = 1'b0;
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic fin);
    step_results.delete();
    if (rec_closed_q) begin
      if (fin) reset_state();
    end else if (b == BYTE_REC_END) begin
      resolve_held();
      push_marker(1'b1, 1'b1, 1'b0);
      clear_subrecord();
      if (fin) reset_state();
      else rec_closed_q = 1'b1;
    end else if (b == BYTE_SUB_END) begin
      resolve_held();
      push_marker(1'b1, 1'b0, 1'b0);
      clear_subrecord();
      if (fin) begin
        push_marker(1'b0, 1'b1, 1'b1);
        reset_state();
      end
    end else begin
      take_byte(b);
      if (fin) begin
        resolve_held();
        push_marker(sub_nonempty_q, 1'b1, 1'b1);
        reset_state();
      end
    end
    if (step_results.size() > 0) begin
      step_results[step_results.size() - 1].run_last = 1'b1;
    end
    expected_tokens = {expected_tokens, step_results};
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches    = 0;
    outstanding_o = 0;
    reset_state();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    item_t e;
    if (!rst_ni) begin
      reset_state();
      expected_tokens.delete();
    end else begin
      if (in_valid_i && in_ready_i) tokenize_byte(data_byte_i, final_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result item: token_byte 0x%0h, kind %0d", token_byte_i,
                 token_kind_i);
          mismatches++;
        end else begin
          e = expected_tokens.pop_front();
          check_field("byte_valid", 8'(e.byte_valid), 8'(byte_valid_i));
          check_field("token_byte", e.token_byte, token_byte_i);
          check_field("token_kind", 8'(e.token_kind), 8'(token_kind_i));
          check_field("token_start", 8'(e.token_start), 8'(token_start_i));
          check_field("token_finish", 8'(e.token_finish), 8'(token_finish_i));
          check_field("text_char", e.text_char, text_char_i);
          check_field("text_char_valid", 8'(e.text_char_valid), 8'(text_char_valid_i));
          check_field("subrecord_end", 8'(e.subrecord_end), 8'(subrecord_end_i));
          check_field("record_end", 8'(e.record_end), 8'(record_end_i));
          check_field("missing_terminator", 8'(e.missing_terminator),
                      8'(missing_terminator_i));
          check_field("run_last", 8'(e.run_last), 8'(run_last_i));
        end
      end
    end
    outstanding_o = expected_tokens.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import trtok_pkg::*;

  localparam int RANDOM_ITEMS = 220;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {
    GEN_PRINT, GEN_RAW, GEN_EOL, GEN_FONT, GEN_POSITION, GEN_IMAGE, GEN_END_PAGE, GEN_NOISE
  } token_gen_e;

  typedef enum int {REC_WELL, REC_NO_TERM, REC_CUT, REC_NOISE} record_shape_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       final_byte;
  logic       out_valid;
  logic       out_ready;
  logic       byte_valid;
  logic [7:0] token_byte;
  logic [2:0] token_kind;
  logic       token_start;
  logic       token_finish;
  logic [7:0] text_char;
  logic       text_char_valid;
  logic       subrecord_end;
  logic       record_end;
  logic       missing_terminator;
  logic       run_last;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_count = 0;
  bit          idle_on;
  bit          hold_req;
  int          sent;
  logic [7:0]  record_bytes[$];

  text_record_control_code_tokenizer dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .data_byte_i         (data_byte),
    .final_byte_i        (final_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .byte_valid_o        (byte_valid),
    .token_byte_o        (token_byte),
    .token_kind_o        (token_kind),
    .token_start_o       (token_start),
    .token_finish_o      (token_finish),
    .text_char_o         (text_char),
    .text_char_valid_o   (text_char_valid),
    .subrecord_end_o     (subrecord_end),
    .record_end_o        (record_end),
    .missing_terminator_o(missing_terminator),
    .run_last_o          (run_last)
  );

  token_stream_checker u_token_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .data_byte_i         (data_byte),
    .final_byte_i        (final_byte),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .byte_valid_i        (byte_valid),
    .token_byte_i        (token_byte),
    .token_kind_i        (token_kind),
    .token_start_i       (token_start),
    .token_finish_i      (token_finish),
    .text_char_i         (text_char),
    .text_char_valid_i   (text_char_valid),
    .subrecord_end_i     (subrecord_end),
    .record_end_i        (record_end),
    .missing_terminator_i(missing_terminator),
    .run_last_i          (run_last),
    .mismatch_count_o    (mismatches),
    .outstanding_o       (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    bit rdy;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send record_bytes with the final flag on the last one
  task automatic send_record();
    bit closed;
    closed = 1'b0;
    foreach (record_bytes[i]) begin
      send_byte(record_bytes[i], i == record_bytes.size() - 1);
      if (!closed) sent++;
      if (record_bytes[i] == BYTE_REC_END) closed = 1'b1;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    record_bytes = {record_bytes, b};
  endfunction

  task automatic append_token();
    token_gen_e kind;
    int         len;
    kind = token_gen_e'($urandom_range(0, GEN_NOISE));
    case (kind)
      GEN_PRINT: add_byte(8'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI)));
      GEN_RAW: add_byte(8'($urandom_range(0, BYTE_END_PAGE - 1)));
      GEN_EOL: begin
        add_byte($urandom_range(0, 1) ? BYTE_EOL_A : BYTE_EOL_B);
        add_byte(BYTE_NUL);
      end
      GEN_FONT: begin
        add_byte($urandom_range(0, 1) ? BYTE_FONT_CODE : BYTE_FONT_COL);
        add_byte(8'($urandom_range(0, 255)));
      end
      GEN_POSITION: begin
        add_byte(8'($urandom_range(BYTE_PRINT_LO, BYTE_PRINT_HI)));
        add_byte(BYTE_POSITION);
        add_byte(8'($urandom_range(0, BYTE_REC_END - 1)));
        add_byte(8'($urandom_range(0, BYTE_REC_END - 1)));
      end
      GEN_IMAGE: begin
        len = $urandom_range(0, 4);
        add_byte(BYTE_IMAGE);
        repeat (len) add_byte(8'($urandom_range(1, BYTE_REC_END - 1)));
        add_byte(BYTE_NUL);
      end
      GEN_END_PAGE: add_byte(BYTE_END_PAGE);
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_random_record();
    record_shape_e shape;
    int            pick;
    int            n_sub;
    int            n_tok;
    int            len;
    pick  = $urandom_range(0, 7);
    shape = (pick < 5) ? REC_WELL : record_shape_e'(pick - 4);
    record_bytes.delete();
    if (shape == REC_NOISE) begin
      len = $urandom_range(1, 8);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
    end else begin
      n_sub = $urandom_range(1, 4);
      for (int s = 0; s < n_sub; s++) begin
        if (s > 0) add_byte(BYTE_SUB_END);
        n_tok = $urandom_range(0, 5);
        repeat (n_tok) append_token();
      end
      if (shape != REC_NO_TERM) begin
        add_byte(BYTE_REC_END);
        len = $urandom_range(0, 2);
        repeat (len) add_byte(8'($urandom_range(0, 255)));
      end
      if (shape == REC_CUT && record_bytes.size() > 1) begin
        len = $urandom_range(1, record_bytes.size() - 1);
        while (record_bytes.size() > len) void'(record_bytes.pop_back());
      end
    end
    if (record_bytes.size() == 0) add_byte(8'($urandom_range(0, 255)));
    send_record();
  endtask

  initial begin
    int  rand_base;
    bit  hold_done;
    bit  drain_done;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    final_byte = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    sent       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Most token kinds (no raw or font color token), then a record closed by 0xFE with a byte after it
    record_bytes = '{BYTE_PRINT_LO, BYTE_PRINT_HI, BYTE_EOL_A, BYTE_NUL, BYTE_FONT_CODE,
                     BYTE_SUB_END, 8'h31, BYTE_POSITION, 8'h12, 8'h34, BYTE_IMAGE, 8'h80,
                     BYTE_NUL, BYTE_END_PAGE, BYTE_REC_END, 8'h55};
    send_record();
    // Held bytes cut off by separators, position with nothing before it,
    // empty subrecord and a missing terminator on a separator
    record_bytes = '{BYTE_POSITION, 8'h1F, BYTE_EOL_B, BYTE_SUB_END, BYTE_IMAGE, 8'h01,
                     BYTE_SUB_END, BYTE_NUL, BYTE_POSITION, 8'h7E, BYTE_SUB_END,
                     BYTE_SUB_END};
    send_record();
    // Missing terminator on a held font byte
    record_bytes = '{8'h80, BYTE_FONT_COL};
    send_record();
    record_bytes = '{BYTE_REC_END};
    send_record();

    rand_base = sent;
    while (sent < rand_base + RANDOM_ITEMS) begin
      if (!hold_done && sent >= rand_base + 70) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && sent >= rand_base + 140) begin
        wait_drained();
        drain_done = 1'b1;
      end
      if (sent >= rand_base + 180) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      send_random_record();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
